[rtl/objilv_pkg.sv]
// Shared types and constants for the OBJ index list validator.
// Holds the character codes, parse phases, status codes and result struct.
// No dependencies; every module of the block imports this package.
package objilv_pkg;

    // Design constants.
    localparam int MAX_ITEMS   = 32;
    localparam int INDEX_BITS  = 24;
    localparam int MAG_BITS    = INDEX_BITS + 1;
    localparam int COUNT_BITS  = 6;
    localparam int MIN_BITS    = 6;
    localparam int SYM_BITS    = 8;
    localparam int CFG_BITS    = 24;
    localparam int STATUS_BITS = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Character codes.
    localparam logic [SYM_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [SYM_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [SYM_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [SYM_BITS-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2B;

    // Reset value of the minimum token count.
    localparam logic [MIN_BITS-1:0] MIN_ITEMS_RESET = 6'd3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_MIN_ITEMS    = 1'b1
    } t_cfg_index;

    // Position inside the current token.
    typedef enum logic [2:0] {
        PH_BETWEEN     = 3'd0,
        PH_LEAD_SIGN   = 3'd1,
        PH_LEAD_DIGITS = 3'd2,
        PH_AFTER_SLASH = 3'd3,
        PH_OPT_SIGN    = 3'd4,
        PH_OPT_DIGITS  = 3'd5
    } t_phase;

    // Verdict codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_SYNTAX   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_TOO_FEW  = 3'd4
    } t_status;

    // One verdict, passed from the parser to the output register.
    typedef struct packed {
        t_status               status;
        logic [COUNT_BITS-1:0] index_count;
    } t_result;

endpackage

[rtl/objilv_parser.sv]
// Token parser of the OBJ index list validator: config registers, parse
// state and the next-state logic for one character.
// Depends on objilv_pkg.
module objilv_parser
    import objilv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_index          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_fire,
    input  logic [SYM_BITS-1:0] i_symbol,
    input  logic                i_end,
    output logic                o_res_valid,
    output t_result             o_result
);

    logic [INDEX_BITS-1:0] r_vertex_count;
    logic [MIN_BITS-1:0]   r_min_items;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_slash, n_slash;
    logic [MAG_BITS-1:0]   r_mag, n_mag;
    logic [COUNT_BITS-1:0] r_tally, n_tally;
    t_status               r_err, n_err;

    localparam logic [MAG_BITS-1:0] MAG_CAP = {1'b1, {INDEX_BITS{1'b0}}};

    // Character classes.
    logic w_sep, w_digit, w_sign, w_slash;
    logic [3:0] w_digit_val;

    assign w_sep   = (i_symbol == CH_SPACE) || (i_symbol == CH_TAB) ||
                     (i_symbol == CH_CR) || (i_symbol == CH_LF);
    assign w_digit = (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE);
    assign w_sign  = (i_symbol == CH_MINUS) || (i_symbol == CH_PLUS);
    assign w_slash = (i_symbol == CH_SLASH);
    assign w_digit_val = 4'(i_symbol - CH_ZERO);

    // Magnitude times ten plus the new digit, saturated at the cap.
    logic [MAG_BITS+3:0] w_prod;
    logic [MAG_BITS-1:0] w_mag_next;

    assign w_prod = ({r_mag, 3'b000} + {2'b00, r_mag, 1'b0}) +
                    (MAG_BITS+4)'(w_digit_val);
    assign w_mag_next = (w_prod > (MAG_BITS+4)'(MAG_CAP)) ? MAG_CAP
                                                          : MAG_BITS'(w_prod);

    // Verdict on the token that a separator or the closing item would end.
    logic    w_digits_phase, w_bad_range, w_close_inc;
    t_status w_close_code;

    assign w_digits_phase = (r_phase == PH_LEAD_DIGITS) || (r_phase == PH_OPT_DIGITS);
    assign w_bad_range = (r_mag == '0) || (r_vertex_count == '0) ||
                         (r_mag > {1'b0, r_vertex_count});
    assign w_close_inc = w_digits_phase && !w_bad_range;

    always_comb begin
        if (w_digits_phase) begin
            w_close_code = w_bad_range ? ST_RANGE : ST_OK;
        end else if (r_phase != PH_BETWEEN) begin
            w_close_code = ST_SYNTAX;
        end else begin
            w_close_code = ST_OK;
        end
    end

    // Next state for one transaction.
    always_comb begin
        logic                  fail;
        t_status               fail_code;
        t_status               final_err;
        logic [COUNT_BITS-1:0] final_tally;

        n_phase     = r_phase;
        n_slash     = r_slash;
        n_mag       = r_mag;
        n_tally     = r_tally;
        n_err       = r_err;
        fail        = 1'b0;
        fail_code   = ST_OK;
        final_err   = r_err;
        final_tally = r_tally;
        o_res_valid = 1'b0;
        o_result.status      = ST_OK;
        o_result.index_count = r_tally;

        if (i_fire && i_end) begin
            // Closing item: judge the open token, report, clear everything.
            if (r_err == ST_OK) begin
                final_err = w_close_code;
                if (w_close_inc) begin
                    final_tally = r_tally + 1'b1;
                end
            end
            o_res_valid = 1'b1;
            o_result.index_count = final_tally;
            if (final_err != ST_OK) begin
                o_result.status = final_err;
            end else if (final_tally < r_min_items) begin
                o_result.status = ST_TOO_FEW;
            end else begin
                o_result.status = ST_OK;
            end
            n_phase = PH_BETWEEN;
            n_slash = 2'd0;
            n_mag   = '0;
            n_tally = '0;
            n_err   = ST_OK;
        end else if (i_fire && (r_err == ST_OK)) begin
            if (w_sep) begin
                // A separator ends any open token.
                if (w_close_code != ST_OK) begin
                    fail      = 1'b1;
                    fail_code = w_close_code;
                end else if (w_close_inc) begin
                    n_tally = r_tally + 1'b1;
                end
                n_phase = PH_BETWEEN;
                n_slash = 2'd0;
                n_mag   = '0;
            end else begin
                unique case (r_phase)
                    PH_BETWEEN: begin
                        if (r_tally >= COUNT_BITS'(MAX_ITEMS)) begin
                            fail      = 1'b1;
                            fail_code = ST_TOO_MANY;
                        end else if (w_sign) begin
                            n_phase = PH_LEAD_SIGN;
                        end else if (w_digit) begin
                            n_mag   = MAG_BITS'(w_digit_val);
                            n_phase = PH_LEAD_DIGITS;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    PH_LEAD_SIGN: begin
                        if (w_digit) begin
                            n_mag   = MAG_BITS'(w_digit_val);
                            n_phase = PH_LEAD_DIGITS;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    PH_LEAD_DIGITS: begin
                        if (w_digit) begin
                            n_mag = w_mag_next;
                        end else if (w_slash) begin
                            n_slash = 2'd1;
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    PH_AFTER_SLASH: begin
                        if (w_slash) begin
                            if (r_slash == 2'd1) begin
                                n_slash = 2'd2;
                            end else begin
                                fail      = 1'b1;
                                fail_code = ST_SYNTAX;
                            end
                        end else if (w_sign) begin
                            n_phase = PH_OPT_SIGN;
                        end else if (w_digit) begin
                            n_phase = PH_OPT_DIGITS;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    PH_OPT_SIGN: begin
                        if (w_digit) begin
                            n_phase = PH_OPT_DIGITS;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    PH_OPT_DIGITS: begin
                        if (w_digit) begin
                            n_phase = r_phase;
                        end else if (w_slash && (r_slash < 2'd2)) begin
                            n_slash = r_slash + 2'd1;
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ST_SYNTAX;
                        end
                    end
                    default: begin
                        fail      = 1'b1;
                        fail_code = ST_SYNTAX;
                    end
                endcase
            end

            // The first error is latched and the token is dropped.
            if (fail) begin
                n_err   = fail_code;
                n_phase = PH_BETWEEN;
                n_slash = 2'd0;
                n_mag   = '0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_min_items    <= MIN_ITEMS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= INDEX_BITS'(i_cfg_data);
                CFG_MIN_ITEMS:    r_min_items    <= MIN_BITS'(i_cfg_data);
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BETWEEN;
            r_slash <= 2'd0;
            r_mag   <= '0;
            r_tally <= '0;
            r_err   <= ST_OK;
        end else begin
            r_phase <= n_phase;
            r_slash <= n_slash;
            r_mag   <= n_mag;
            r_tally <= n_tally;
            r_err   <= n_err;
        end
    end

endmodule

[rtl/objilv_out_reg.sv]
// Output register of the OBJ index list validator: holds one verdict
// until the downstream side takes it. Depends on objilv_pkg.
module objilv_out_reg
    import objilv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_result              i_result,
    output logic                 o_can_accept,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata  // [2:0] status, [8:3] index_count
);

    logic    r_valid, n_valid;
    t_result r_result;

    // The register frees up in the same cycle its content is taken.
    assign o_can_accept = !r_valid || m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_accept) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_accept && i_valid) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_result.index_count, r_result.status});

endmodule

[rtl/obj_index_list_validator.sv]
// Top level of the OBJ face/line index list validator.
// Holds the input register; instantiates objilv_parser and objilv_out_reg.
// Depends on objilv_pkg.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] symbol, tlast list_end
//   m_axis    out        tdata[2:0] status, tdata[8:3] index_count
//   cfg       in         index 0 vertex_count, index 1 min_items
//
// One character is taken per cycle unless a held closing item faces a full
// output; a character costs one pass through the parser's state update with
// its multiply-by-ten add. A closing verdict passes the input register and
// the output register to m_axis. Only a closing transaction waits on the
// output register; input waits only behind a held closing item. Reset is
// synchronous and leaves the block ready, with vertex_count 0, min_items 3.
module obj_index_list_validator
    import objilv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] symbol
    input  logic                 s_axis_tlast,  // list_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [2:0] status, [8:3] index_count
);

    logic                r_in_valid;
    logic [SYM_BITS-1:0] r_in_symbol;
    logic                r_in_end;
    logic                w_consume;
    logic                w_can_accept;
    logic                w_res_valid;
    t_result             w_result;

    // The held item moves on unless it is a closing item facing a full output.
    assign w_consume     = r_in_valid && (!r_in_end || w_can_accept);
    assign s_axis_tready = !r_in_valid || w_consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_symbol <= s_axis_tdata[SYM_BITS-1:0];
            r_in_end    <= s_axis_tlast;
        end
    end

    objilv_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_consume),
        .i_symbol    (r_in_symbol),
        .i_end       (r_in_end),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    objilv_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_res_valid),
        .i_result      (w_result),
        .o_can_accept  (w_can_accept),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for obj_index_list_validator.
// A driver streams characters and closing transactions with random gaps; a monitor
// predicts each verdict and compares it. Depends on objilv_pkg and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import objilv_pkg::*;

    localparam int              CLK_HALF        = 6;
    localparam int unsigned     CYCLE_LIMIT     = 200000;
    localparam int              SETTLE_CYCLES   = 8;
    localparam int              ITEMS_PER_PHASE = 110;
    localparam int              RAND_PHASES     = 8;
    localparam longint unsigned MAG_CAP         = 64'd1 << INDEX_BITS;

    // One character or closing transaction waiting for the driver.
    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                list_end;
    } t_char_txn;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_index   = CFG_VERTEX_COUNT;
    logic [CFG_BITS-1:0]  i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [7:0] symbol
    logic                 s_axis_tlast  = 1'b0; // list_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [2:0] status, [8:3] index_count

    t_char_txn   pending_chars[$];
    t_result     verdicts_due[$];
    int unsigned pushed_items = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;

    // Parser state and register copies used to predict verdicts.
    t_phase              tok_phase   = PH_BETWEEN;
    logic [1:0]          tok_slashes = '0;
    longint unsigned     tok_mag     = 0;
    int unsigned         tok_tally   = 0;
    t_status             list_error  = ST_OK;
    logic [CFG_BITS-1:0] bound_vc    = '0;
    logic [MIN_BITS-1:0] bound_min   = MIN_ITEMS_RESET;

    obj_index_list_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Cycle count and run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Idle now and then, but never in the early part of each window of the cycle count.
    function automatic bit want_idle();
        return ((cycles % 3000) >= 900) && ($urandom_range(99) < 11);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- prediction

    function automatic bit is_sep(logic [SYM_BITS-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit is_dig(logic [SYM_BITS-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void drop_token();
        tok_phase   = PH_BETWEEN;
        tok_slashes = '0;
        tok_mag     = 0;
    endfunction

    // Only the first error of a list is kept.
    function automatic void flag_error(t_status code);
        if (list_error == ST_OK)
            list_error = code;
        drop_token();
    endfunction

    // A token ends: syntax is judged first, then the range of its leading index.
    function automatic void end_token();
        if (tok_phase == PH_LEAD_DIGITS || tok_phase == PH_OPT_DIGITS) begin
            if (tok_mag == 0 || bound_vc == 0 || tok_mag > bound_vc) begin
                flag_error(ST_RANGE);
            end else begin
                tok_tally++;
                drop_token();
            end
        end else if (tok_phase != PH_BETWEEN) begin
            flag_error(ST_SYNTAX);
        end
    endfunction

    function automatic void scan_char(logic [SYM_BITS-1:0] c);
        longint unsigned grown;
        if (is_sep(c)) begin
            end_token();
            return;
        end
        case (tok_phase)
            PH_BETWEEN: begin
                // The token limit is checked before the token's syntax.
                if (tok_tally >= MAX_ITEMS) flag_error(ST_TOO_MANY);
                else if (c == CH_MINUS || c == CH_PLUS) tok_phase = PH_LEAD_SIGN;
                else if (is_dig(c)) begin
                    tok_mag   = c - CH_ZERO;
                    tok_phase = PH_LEAD_DIGITS;
                end else flag_error(ST_SYNTAX);
            end
            PH_LEAD_SIGN: begin
                if (is_dig(c)) begin
                    tok_mag   = c - CH_ZERO;
                    tok_phase = PH_LEAD_DIGITS;
                end else flag_error(ST_SYNTAX);
            end
            PH_LEAD_DIGITS: begin
                if (is_dig(c)) begin
                    grown   = tok_mag * 10 + (c - CH_ZERO);
                    tok_mag = (grown > MAG_CAP) ? MAG_CAP : grown;
                end else if (c == CH_SLASH) begin
                    tok_slashes = 2'd1;
                    tok_phase   = PH_AFTER_SLASH;
                end else flag_error(ST_SYNTAX);
            end
            PH_AFTER_SLASH: begin
                if (c == CH_SLASH) begin
                    if (tok_slashes == 2'd1) tok_slashes = 2'd2;
                    else flag_error(ST_SYNTAX);
                end else if (c == CH_MINUS || c == CH_PLUS) tok_phase = PH_OPT_SIGN;
                else if (is_dig(c)) tok_phase = PH_OPT_DIGITS;
                else flag_error(ST_SYNTAX);
            end
            PH_OPT_SIGN: begin
                if (is_dig(c)) tok_phase = PH_OPT_DIGITS;
                else flag_error(ST_SYNTAX);
            end
            PH_OPT_DIGITS: begin
                if (!is_dig(c)) begin
                    if (c == CH_SLASH && tok_slashes < 2'd2) begin
                        tok_slashes = tok_slashes + 2'd1;
                        tok_phase   = PH_AFTER_SLASH;
                    end else flag_error(ST_SYNTAX);
                end
            end
            default: flag_error(ST_SYNTAX);
        endcase
    endfunction

    // Returns 1 with the verdict when the transaction closes a list.
    function automatic bit take_item(logic [SYM_BITS-1:0] c, logic last,
                                     output t_result verdict);
        verdict = '0;
        if (!last) begin
            if (list_error == ST_OK)
                scan_char(c);
            return 1'b0;
        end
        if (list_error == ST_OK)
            end_token();
        verdict.status = list_error;
        if (list_error == ST_OK && tok_tally < bound_min)
            verdict.status = ST_TOO_FEW;
        verdict.index_count = COUNT_BITS'(tok_tally);
        drop_token();
        tok_tally  = 0;
        list_error = ST_OK;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_char(logic [SYM_BITS-1:0] c);
        pending_chars.push_back('{symbol: c, list_end: 1'b0});
        pushed_items++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endfunction

    // The symbol of a closing transaction is don't-care, so it is random.
    function automatic void queue_close();
        pending_chars.push_back('{symbol: SYM_BITS'($urandom), list_end: 1'b1});
        pushed_items++;
    endfunction

    function automatic logic [SYM_BITS-1:0] pick_sep();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic string digits_text(int n);
        string s = "";
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%0d", s, $urandom_range(9));
        return s;
    endfunction

    // Optional part after a slash: an optional sign and a few digits.
    function automatic string opt_part();
        string s = "";
        int    r;
        r = $urandom_range(99);
        if (r < 5) s = "-";
        else if (r < 10) s = "+";
        return {s, digits_text($urandom_range(1, 3))};
    endfunction

    // A well-formed token whose leading index may still be out of range.
    function automatic string make_token(bit tiny);
        string           s = "";
        longint unsigned mag;
        int              r;
        r = $urandom_range(99);
        if (r < 10) s = "-";
        else if (r < 15) s = "+";
        if ($urandom_range(19) == 0)
            s = {s, "0"};
        r = $urandom_range(99);
        if (tiny)
            mag = (bound_vc == 0) ? 1 : $urandom_range(1, (bound_vc < 9) ? bound_vc : 9);
        else if (r < 68)
            mag = (bound_vc == 0) ? $urandom_range(9) : $urandom_range(1, bound_vc);
        else if (r < 76) mag = 0;
        else if (r < 83) mag = bound_vc;
        else if (r < 90) mag = bound_vc + 1;
        else mag = $urandom_range(999);
        // Very long digit strings drive the magnitude into saturation.
        if (!tiny && r >= 95)
            s = {s, digits_text($urandom_range(8, 12))};
        else
            s = {s, $sformatf("%0d", mag)};
        r = $urandom_range(99);
        if (tiny && r >= 10) return s;
        if (r < 40) return s;
        if (r < 60) return {s, "/", opt_part()};
        if (r < 85) return {s, "/", opt_part(), "/", opt_part()};
        return {s, "//", opt_part()};
    endfunction

    // Something that breaks the token it is appended to, or sometimes not.
    function automatic void queue_damage();
        case ($urandom_range(5))
            0:       queue_text("/");
            1:       queue_text("//");
            2:       queue_text("x");
            3:       queue_text("-");
            4:       queue_text("/1/2/3");
            default: queue_char(SYM_BITS'($urandom));
        endcase
    endfunction

    function automatic void queue_random_list();
        int ntok;
        int r;
        bit tiny = 1'b0;
        r = $urandom_range(99);
        if (r < 6) begin
            // Long lists of short tokens come close to or past the token limit.
            ntok = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 2);
            tiny = 1'b1;
        end else if (r < 10) begin
            ntok = 0;
        end else begin
            ntok = $urandom_range(1, 7);
        end
        if ($urandom_range(3) == 0)
            queue_char(pick_sep());
        for (int i = 0; i < ntok; i++) begin
            if ($urandom_range(49) == 0)
                queue_char(SYM_BITS'($urandom));
            queue_text(make_token(tiny));
            if ($urandom_range(15) == 0)
                queue_damage();
            if (i < ntok - 1 || $urandom_range(1) == 1) begin
                queue_char(pick_sep());
                if ($urandom_range(7) == 0)
                    queue_char(pick_sep());
            end
        end
        queue_close();
    endfunction

    // Registers are written only while nothing is in flight.
    task automatic write_reg(t_cfg_index idx, logic [CFG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) bound_vc = val;
        else bound_min = val[MIN_BITS-1:0];
    endtask

    task automatic settle();
        while (pending_chars.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [CFG_BITS-1:0] vc;
        logic [CFG_BITS-1:0] mn;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset vertex count every index is out of range.
        queue_text("7");
        queue_close();
        settle();

        // Extremes: empty list, all token forms, signed zero, saturation, NUL.
        write_reg(CFG_VERTEX_COUNT, {CFG_BITS{1'b1}});
        write_reg(CFG_MIN_ITEMS, CFG_BITS'(1));
        queue_close();
        queue_text("1/-2/3 4//5\t+6\r\n");
        queue_close();
        queue_text("-0 99999999");
        queue_close();
        queue_text("8/+");
        queue_char(8'h00);
        queue_close();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin vc = CFG_BITS'(1);  mn = CFG_BITS'(2);  end
                1: begin vc = {CFG_BITS{1'b1}}; mn = CFG_BITS'(0); end
                2: begin vc = CFG_BITS'(0);  mn = CFG_BITS'(3);  end
                3: begin vc = CFG_BITS'(37); mn = CFG_BITS'(63); end
                4: begin
                    vc = CFG_BITS'($urandom_range(2, 20));
                    mn = CFG_BITS'(MAX_ITEMS);
                end
                5: begin vc = CFG_BITS'(9);  mn = CFG_BITS'(MAX_ITEMS + 1); end
                6: begin
                    vc = CFG_BITS'($urandom);
                    mn = CFG_BITS'($urandom_range(1, 4));
                end
                default: begin
                    vc = CFG_BITS'($urandom_range(1, 500));
                    mn = CFG_BITS'(3);
                end
            endcase
            write_reg(CFG_VERTEX_COUNT, vc);
            write_reg(CFG_MIN_ITEMS, mn);
            pushed_items = 0;
            while (pushed_items < ITEMS_PER_PHASE)
                queue_random_list();
        end

        settle();
        if (verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        t_char_txn nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_chars.size() != 0 && !want_idle()) begin
                nxt = pending_chars.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.symbol;
                s_axis_tlast  <= nxt.list_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_result verdict;
        t_result want;
        m_axis_tready <= !want_idle();

        // Each accepted input transaction advances the prediction.
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (take_item(s_axis_tdata, s_axis_tlast, verdict))
                verdicts_due.push_back(verdict);
        end

        // Each accepted output transaction is checked against the oldest verdict.
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected verdict tdata=%h", m_axis_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              m_axis_tdata[2:0], want.status));
                if (m_axis_tdata[8:3] != want.index_count)
                    report_mismatch($sformatf("index_count %0d, predicted %0d",
                                              m_axis_tdata[8:3], want.index_count));
            end
        end
    end

endmodule

[sim.f]
rtl/objilv_pkg.sv
rtl/objilv_parser.sv
rtl/objilv_out_reg.sv
rtl/obj_index_list_validator.sv
bench/tb_top.sv
